// ----- rtl/core/pepe_pkg.sv -----
// Package for the periodic event phase estimator.
// Holds opcodes, status codes and widths shared by the core modules.
package pepe_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PeriodW = 20;
  localparam int unsigned TolW    = 19;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 20;

  localparam logic [TimeW-1:0]   ZeroTime     = '0;
  localparam logic [PeriodW-1:0] PeriodReset  = 20'd86400;
  localparam logic [TolW-1:0]    TolReset     = 19'd3600;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_TEST = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EARLY      = 2'd1,
    ST_INCOHERENT = 2'd2,
    ST_RSVD       = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD = 1'b0,
    CFG_TOL    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              opcode;
    logic [TimeW-1:0]  sample_time;
  } req_t;

  typedef struct packed {
    logic              sample_good;
    logic [TimeW-1:0]  estimate_time;
    logic [1:0]        status;
  } rsp_t;

  // Start/done bundle between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ----- rtl/core/pepe_if.sv -----
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; the payload type is a parameter.
interface pepe_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/periodic_event_phase_estimator.sv -----
// Top level of the periodic event phase estimator.
// Depends on pepe_pkg, pepe_if, pepe_seq and pepe_div.
//
// Requests arrive on req_if: opcode 0 pushes sample_time into a ring of the
// RING_DEPTH newest timestamps, opcode 1 tests sample_time against the set.
// Each request yields exactly one response on rsp_if, with sample_good,
// estimate_time and status.
// A push or a test of an empty ring presents its response in the cycle after
// acceptance. A test walks the older entries one by one; each entry uses the
// shared restoring divider for its period projection, and the average and the
// final check use it once more each; an early sample skips the final check.
// The block takes one request at a time and is not ready while it works
// or while a response waits; a stalled receiver holds the response.
// Reset empties the ring and restores period 86400 and tolerance 3600.
// Configuration writes go to cfg_we_i, cfg_idx_i and cfg_data_i; the user
// is to make them only while idle, and the block does not enforce this.
module periodic_event_phase_estimator #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pepe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pepe_pkg::CfgW-1:0]    cfg_data_i,
  pepe_if.sink                         req_if,
  pepe_if.source                       rsp_if
);
  logic [pepe_pkg::PeriodW-1:0] period_q;
  logic [pepe_pkg::TolW-1:0]    tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= pepe_pkg::PeriodReset;
      tol_q    <= pepe_pkg::TolReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pepe_pkg::CFG_PERIOD: period_q <= cfg_data_i[pepe_pkg::PeriodW-1:0];
        pepe_pkg::CFG_TOL:    tol_q    <= cfg_data_i[pepe_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  pepe_seq #(.RingDepth(RING_DEPTH)) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .period_i(period_q),
    .tol_i   (tol_q),
    .req_if  (req_if),
    .rsp_if  (rsp_if)
  );
endmodule

// ----- rtl/core/pepe_div.sv -----
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on no other file; the sequencer wires its control ports to the pepe_pkg bundle.
module pepe_div #(
  parameter int unsigned NumW = 34,
  parameter int unsigned DenW = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NumW-1:0]       num_i,
  input  logic [DenW-1:0]       den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [NumW-1:0]       quo_o,
  output logic [DenW-1:0]       rem_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DenW:0]   trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[NumW-1]} - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!trial[DenW]) begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DenW-2:0], quo_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ----- rtl/core/pepe_seq.sv -----
// Sequencer: ring storage, walk over older entries, projection, averaging and the final check.
// Depends on pepe_pkg, pepe_if and the shared divider pepe_div.
module pepe_seq #(
  parameter int unsigned RingDepth = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pepe_pkg::PeriodW-1:0] period_i,
  input  logic [pepe_pkg::TolW-1:0]    tol_i,
  pepe_if.sink                        req_if,
  pepe_if.source                      rsp_if
);
  localparam int unsigned SlotW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int unsigned CntW  = $clog2(RingDepth + 1);
  localparam int unsigned DivNW = 34;
  localparam int unsigned TW    = pepe_pkg::TimeW;
  localparam int unsigned PW    = pepe_pkg::PeriodW;
  localparam int unsigned SumW  = 40;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDN   = 10'b0000000010,
    S_RDOLD = 10'b0000000100,
    S_DIFF  = 10'b0000001000,
    S_PDIV  = 10'b0000010000,
    S_PEVAL = 10'b0000100000,
    S_ADIV  = 10'b0001000000,
    S_AEVAL = 10'b0010000000,
    S_FDIV  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [TW-1:0]    ring_mem [RingDepth];
  logic [TW-1:0]    rd_q;
  logic [SlotW-1:0] rd_addr;
  logic [SlotW-1:0] newest_q, newest_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [TW-1:0]    sample_q, sample_d;
  logic [TW-1:0]    ref_q, ref_d;
  logic [TW-1:0]    newv_q, newv_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [PW-1:0]    per_q, per_d;
  logic [PW:0]      lim_q, lim_d;
  logic             final_q, final_d;
  logic             neg_q, neg_d;
  pepe_pkg::rsp_t   rsp_q, rsp_d;
  logic             rvalid_q, rvalid_d;

  logic             div_start;
  logic [DivNW-1:0] div_num;
  logic [PW-1:0]    div_den;
  pepe_pkg::div_ctl_t div_ctl;
  logic [DivNW-1:0] div_quo;
  logic [PW-1:0]    div_rem;

  logic [TW-1:0]    t_val;
  logic [TW:0]      diff;
  logic [PW:0]      w_val;
  logic [PW:0]      pmw;
  logic [SumW-1:0]  avg_mag;
  logic [SumW-1:0]  avg;
  logic [TW-1:0]    est;
  logic             wr_en;
  logic [SlotW-1:0] wr_slot;

  pepe_div #(.NumW(DivNW), .DenW(PW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_ctl.start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_ctl.busy),
    .done_o (div_ctl.done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  assign req_if.ready = (state_q == S_IDLE) && !rvalid_q;
  assign rsp_if.valid = rvalid_q;
  assign rsp_if.data  = rsp_q;
  assign div_ctl.start = div_start;

  always_comb begin
    if (newest_q == SlotW'(RingDepth - 1)) begin
      wr_slot = '0;
    end else begin
      wr_slot = newest_q + 1'b1;
    end
    if (newest_q >= SlotW'(idx_q)) begin
      rd_addr = newest_q - SlotW'(idx_q);
    end else begin
      rd_addr = SlotW'(RingDepth) + newest_q - SlotW'(idx_q);
    end
  end

  assign wr_en = req_if.valid && req_if.ready &&
                 (req_if.data.opcode == pepe_pkg::OP_PUSH);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_slot] <= req_if.data.sample_time;
    end
    rd_q <= ring_mem[rd_addr];
  end

  always_comb begin
    state_d   = state_q;
    newest_d  = newest_q;
    count_d   = count_q;
    idx_d     = idx_q;
    sample_d  = sample_q;
    ref_d     = ref_q;
    newv_d    = newv_q;
    sum_d     = sum_q;
    per_d     = per_q;
    lim_d     = lim_q;
    final_d   = final_q;
    neg_d     = neg_q;
    rsp_d     = rsp_q;
    rvalid_d  = rvalid_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = per_q;
    t_val     = final_q ? newv_q : rd_q;
    diff      = {1'b0, ref_q} - {1'b0, t_val};
    w_val     = (PW+1)'(per_q) - (PW+1)'(div_rem);
    if (div_rem == '0) begin
      w_val = '0;
    end
    pmw       = (PW+1)'(per_q) - w_val;
    avg_mag   = SumW'(div_quo);
    avg       = neg_q ? (~avg_mag + 1'b1) : avg_mag;
    est       = newv_q + avg[TW-1:0];

    if (rsp_if.valid && rsp_if.ready) begin
      rvalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_if.valid && req_if.ready) begin
          sample_d = req_if.data.sample_time;
          per_d    = (period_i == '0) ? PW'(1) : period_i;
          if (req_if.data.opcode == pepe_pkg::OP_PUSH) begin
            newest_d = wr_slot;
            if (count_q != CntW'(RingDepth)) begin
              count_d = count_q + 1'b1;
            end
            rsp_d    = '0;
            rvalid_d = 1'b1;
          end else if (count_q == '0) begin
            rsp_d             = '0;
            rsp_d.sample_good = 1'b1;
            rvalid_d          = 1'b1;
          end else begin
            idx_d   = '0;
            sum_d   = '0;
            lim_d   = {1'b0, tol_i, 1'b0};
            final_d = 1'b0;
            state_d = S_RDN;
          end
        end
      end
      S_RDN: begin
        idx_d   = CntW'(1);
        state_d = S_RDOLD;
      end
      S_RDOLD: begin
        newv_d = rd_q;
        ref_d  = rd_q;
        if (count_q == CntW'(1)) begin
          state_d = S_ADIV;
        end else begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        if (!final_q && (rd_q > ref_q)) begin
          rsp_d        = '0;
          rsp_d.status = pepe_pkg::ST_INCOHERENT;
          rvalid_d     = 1'b1;
          state_d      = S_IDLE;
        end else begin
          div_start = 1'b1;
          div_num   = DivNW'(diff[TW-1:0]);
          state_d   = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_ctl.done) begin
          state_d = S_PEVAL;
        end
      end
      S_PEVAL: begin
        // Equal times give a zero quotient and remainder; the projection lands a full period past.
        if ((div_rem == '0) && (div_quo == '0)) begin
          w_val = (PW+1)'(per_q);
          pmw   = '0;
        end
        if (final_q) begin
          rsp_d.sample_good = (w_val < lim_q) || (pmw < lim_q);
          rvalid_d          = 1'b1;
          state_d           = S_IDLE;
        end else if (w_val < lim_q) begin
          sum_d = sum_q + SumW'(w_val);
          state_d = S_AEVAL;
        end else if (pmw < lim_q) begin
          sum_d = sum_q - SumW'(pmw);
          state_d = S_AEVAL;
        end else begin
          rsp_d        = '0;
          rsp_d.status = pepe_pkg::ST_INCOHERENT;
          rvalid_d     = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_AEVAL: begin
        if (idx_q == count_q - 1'b1) begin
          state_d = S_ADIV;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FDIV;
        end
      end
      S_FDIV: begin
        state_d = S_DIFF;
      end
      S_ADIV: begin
        neg_d     = sum_q[SumW-1];
        div_start = 1'b1;
        div_num   = DivNW'(sum_q[SumW-1] ? (~sum_q + 1'b1) : sum_q);
        div_den   = PW'(count_q);
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (div_ctl.done) begin
          rsp_d               = '0;
          rsp_d.estimate_time = est;
          if (sample_q < est) begin
            rsp_d.status = pepe_pkg::ST_EARLY;
            rvalid_d     = 1'b1;
            state_d      = S_IDLE;
          end else begin
            newv_d  = est;
            ref_d   = sample_q;
            lim_d   = {2'b0, tol_i};
            final_d = 1'b1;
            div_start = 1'b1;
            div_num   = DivNW'(sample_q - est);
            div_den   = per_q;
            state_d   = S_PDIV;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      newest_q <= '0;
      count_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      newest_q <= newest_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    sample_q <= sample_d;
    ref_q    <= ref_d;
    newv_q   <= newv_d;
    sum_q    <= sum_d;
    per_q    <= per_d;
    lim_q    <= lim_d;
    final_q  <= final_d;
    neg_q    <= neg_d;
    rsp_q    <= rsp_d;
  end
endmodule
